// ===== hw/rtl/llnpm_pkg.sv =====
`default_nettype none
package llnpm_pkg;

  localparam int DATA_W         = 32;
  localparam int CMD_W          = 3;
  localparam int STATUS_W       = 2;
  localparam int POOL_NODES_DEF = 64;
  localparam int STOCK_DEPTH_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                latch_in;
    logic                clear;
    logic                alloc_pop;
    logic                alloc_fresh;
    logic                load_from_stock;
    logic                write_node;
    logic                next_head;
    logic                set_head_node;
    logic                walk_start;
    logic                walk_step;
    logic                link;
    logic                rem_read;
    logic                rem_update;
    logic                list_start;
    logic                list_emit;
    logic                emit_result;
    logic [STATUS_W-1:0] emit_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_null;
    logic stock_empty;
    logic fresh_avail;
    logic walk_stop;
    logic list_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/linked_list_node_pool_manager_unit.sv =====
`default_nettype none
// Linked list of 32-bit values kept in a fixed pool of POOL_NODES nodes.
// Input channel (in_valid/in_ready) carries command and value_in; a transfer
// happens when both are high. Commands: clear, insert at head, insert at
// tail, remove head, list all. Output channel (out_valid/out_ready) carries
// status, value_out and last; every command gives one result with last set,
// except list, which gives one result per element with last on the final
// one. Unknown command codes are consumed with no result.
// From input transfer to the result being loaded: clear and an empty
// remove or list go straight to emission; a head insert allocates a node
// (with an extra wait state when it comes from the recycled stack), writes
// it and emits; a tail insert also walks the list node by node before it
// links; remove reads the head node, then updates the head; list reads the
// head and then shows one element per cycle while the output is free. The
// walks are bound by the single read port of the node memory.
// Only one command is worked on at a time, but the output register lets the
// next command be taken while a finished result still waits. When the
// receiver stalls, the block finishes the command and holds its result;
// a list simply pauses. Reset empties the list and returns the whole pool
// and the recycled stack to the unused state; memories need no clearing.
module linked_list_node_pool_manager_unit #(
  parameter int POOL_NODES  = llnpm_pkg::POOL_NODES_DEF,
  parameter int STOCK_DEPTH = llnpm_pkg::STOCK_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [llnpm_pkg::CMD_W-1:0]         command,
  input  wire  signed [llnpm_pkg::DATA_W-1:0] value_in,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [llnpm_pkg::STATUS_W-1:0]      status,
  output logic signed [llnpm_pkg::DATA_W-1:0] value_out,
  output logic                                last
);

  // Command and status bundles between the sequencer and the datapath.
  llnpm_pkg::dp_cmd_t cmd;
  llnpm_pkg::dp_sts_t sts;

  // The controller decodes each accepted command and steps through
  // allocation, list walks and result emission.
  llnpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the node memories, the recycled-index stack, the
  // head pointer and counters, and the output register.
  llnpm_dpath #(
    .POOL_NODES  (POOL_NODES),
    .STOCK_DEPTH (STOCK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .value_in  (value_in),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .value_out (value_out),
    .last      (last)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/llnpm_dpath.sv =====
`default_nettype none
module llnpm_dpath #(
  parameter int POOL_NODES  = llnpm_pkg::POOL_NODES_DEF,
  parameter int STOCK_DEPTH = llnpm_pkg::STOCK_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  signed [llnpm_pkg::DATA_W-1:0] value_in,
  input  wire  llnpm_pkg::dp_cmd_t            cmd,
  output llnpm_pkg::dp_sts_t                  sts,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [llnpm_pkg::STATUS_W-1:0]      status,
  output logic signed [llnpm_pkg::DATA_W-1:0] value_out,
  output logic                                last
);

  localparam int AW  = $clog2(POOL_NODES);
  localparam int IW  = $clog2(POOL_NODES + 1);
  localparam int SAW = $clog2(STOCK_DEPTH);
  localparam int SCW = $clog2(STOCK_DEPTH + 1);
  localparam logic [IW-1:0]  NULL_IDX   = IW'(POOL_NODES);
  localparam logic [IW-1:0]  LAST_CNT   = IW'(POOL_NODES - 1);
  localparam logic [SCW-1:0] STOCK_FULL = SCW'(STOCK_DEPTH);

  logic [llnpm_pkg::DATA_W-1:0] node_value_mem [POOL_NODES];
  logic [IW-1:0]                node_next_mem  [POOL_NODES];
  logic [AW-1:0]                stock_mem      [STOCK_DEPTH];

  logic [IW-1:0]                head;
  logic [SCW-1:0]               stock_count;
  logic [IW-1:0]                fresh_count;
  logic [AW-1:0]                node_n;
  logic [AW-1:0]                cur;
  logic [IW-1:0]                cnt;
  logic [llnpm_pkg::DATA_W-1:0] val_q;
  logic [llnpm_pkg::DATA_W-1:0] rd_value;
  logic [IW-1:0]                rd_next;
  logic [AW-1:0]                stk_rd;

  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic                         nx_wr_en;
  logic [AW-1:0]                nx_wr_addr;
  logic [IW-1:0]                nx_wr_data;
  logic [SCW-1:0]               stock_dec;
  logic                         stock_room;
  logic                         out_load;

  assign stock_dec  = stock_count - SCW'(1);
  assign stock_room = stock_count < STOCK_FULL;
  assign out_load   = cmd.emit_result | cmd.list_emit;

  assign sts.head_null   = head >= NULL_IDX;
  assign sts.stock_empty = stock_count == '0;
  assign sts.fresh_avail = fresh_count < NULL_IDX;
  assign sts.walk_stop   = (cnt >= NULL_IDX) || (rd_next >= NULL_IDX);
  assign sts.list_last   = (cnt == LAST_CNT) || (rd_next >= NULL_IDX);
  assign sts.out_free    = !out_valid || out_ready;

  always_comb begin
    rd_addr = head[AW-1:0];
    if (cmd.walk_step || cmd.list_emit) begin
      rd_addr = rd_next[AW-1:0];
    end
    rd_en = cmd.walk_start | cmd.walk_step | cmd.rem_read | cmd.list_start |
            (cmd.list_emit & !sts.list_last);
    nx_wr_en   = cmd.write_node | cmd.link;
    nx_wr_addr = cmd.link ? cur : node_n;
    if (cmd.link) begin
      nx_wr_data = IW'(node_n);
    end else if (cmd.next_head) begin
      nx_wr_data = head;
    end else begin
      nx_wr_data = NULL_IDX;
    end
  end

  // Node pool: one read port and one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_value <= node_value_mem[rd_addr];
      rd_next  <= node_next_mem[rd_addr];
    end
    if (cmd.write_node) begin
      node_value_mem[node_n] <= val_q;
    end
    if (nx_wr_en) begin
      node_next_mem[nx_wr_addr] <= nx_wr_data;
    end
  end

  // Stack of recycled node indices.
  always_ff @(posedge clk) begin
    if (cmd.alloc_pop) begin
      stk_rd <= stock_mem[stock_dec[SAW-1:0]];
    end
    if (cmd.rem_update && stock_room) begin
      stock_mem[stock_count[SAW-1:0]] <= head[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= NULL_IDX;
      stock_count <= '0;
      fresh_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        head <= NULL_IDX;
      end else if (cmd.set_head_node) begin
        head <= IW'(node_n);
      end else if (cmd.rem_update) begin
        head <= (rd_next < NULL_IDX) ? rd_next : NULL_IDX;
      end

      if (cmd.clear) begin
        stock_count <= '0;
      end else if (cmd.alloc_pop) begin
        stock_count <= stock_dec;
      end else if (cmd.rem_update && stock_room) begin
        stock_count <= stock_count + SCW'(1);
      end

      if (cmd.clear) begin
        fresh_count <= '0;
      end else if (cmd.alloc_fresh) begin
        fresh_count <= fresh_count + IW'(1);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      val_q <= value_in;
    end
    if (cmd.alloc_fresh) begin
      node_n <= fresh_count[AW-1:0];
    end else if (cmd.load_from_stock) begin
      node_n <= stk_rd;
    end
    if (cmd.walk_start) begin
      cur <= head[AW-1:0];
    end else if (cmd.walk_step) begin
      cur <= rd_next[AW-1:0];
    end
    if (cmd.walk_start) begin
      cnt <= IW'(1);
    end else if (cmd.list_start) begin
      cnt <= '0;
    end else if (cmd.walk_step || cmd.list_emit) begin
      cnt <= cnt + IW'(1);
    end
    if (cmd.emit_result) begin
      status    <= cmd.emit_status;
      value_out <= '0;
      last      <= 1'b1;
    end else if (cmd.list_emit) begin
      status    <= llnpm_pkg::ST_OK;
      value_out <= rd_value;
      last      <= sts.list_last;
    end
  end

  a_stock_bound: assert property (@(posedge clk) disable iff (rst)
    stock_count <= STOCK_FULL)
    else $error("stock count beyond stack depth");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_count <= NULL_IDX)
    else $error("fresh count beyond pool size");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= NULL_IDX)
    else $error("head index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> sts.out_free)
    else $error("output register loaded while a result is pending");

endmodule
`default_nettype wire

// ===== hw/rtl/llnpm_ctrl.sv =====
`default_nettype none
module llnpm_ctrl (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [llnpm_pkg::CMD_W-1:0]   command,
  input  wire  llnpm_pkg::dp_sts_t      sts,
  output llnpm_pkg::dp_cmd_t            cmd
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_ALLOC      = 4'd1;
  localparam logic [3:0] S_ALLOC_WAIT = 4'd2;
  localparam logic [3:0] S_WRITE      = 4'd3;
  localparam logic [3:0] S_WALK       = 4'd4;
  localparam logic [3:0] S_REM_RD     = 4'd5;
  localparam logic [3:0] S_REM_UPD    = 4'd6;
  localparam logic [3:0] S_LIST_RD    = 4'd7;
  localparam logic [3:0] S_LIST_OUT   = 4'd8;
  localparam logic [3:0] S_EMIT       = 4'd9;

  logic [3:0]                      state;
  logic [3:0]                      state_next;
  logic                            is_tail;
  logic                            is_tail_next;
  logic [llnpm_pkg::STATUS_W-1:0]  res_status;
  logic [llnpm_pkg::STATUS_W-1:0]  res_status_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next          = state;
    is_tail_next        = is_tail;
    res_status_next     = res_status;
    cmd.emit_status     = res_status;
    cmd.latch_in        = 1'b0;
    cmd.clear           = 1'b0;
    cmd.alloc_pop       = 1'b0;
    cmd.alloc_fresh     = 1'b0;
    cmd.load_from_stock = 1'b0;
    cmd.write_node      = 1'b0;
    cmd.next_head       = 1'b0;
    cmd.set_head_node   = 1'b0;
    cmd.walk_start      = 1'b0;
    cmd.walk_step       = 1'b0;
    cmd.link            = 1'b0;
    cmd.rem_read        = 1'b0;
    cmd.rem_update      = 1'b0;
    cmd.list_start      = 1'b0;
    cmd.list_emit       = 1'b0;
    cmd.emit_result     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          is_tail_next = command == llnpm_pkg::CMD_INS_TAIL;
          case (command)
            llnpm_pkg::CMD_CLEAR: begin
              cmd.clear       = 1'b1;
              res_status_next = llnpm_pkg::ST_OK;
              state_next      = S_EMIT;
            end
            llnpm_pkg::CMD_INS_HEAD, llnpm_pkg::CMD_INS_TAIL: begin
              state_next = S_ALLOC;
            end
            llnpm_pkg::CMD_REMOVE: begin
              if (sts.head_null) begin
                res_status_next = llnpm_pkg::ST_EMPTY;
                state_next      = S_EMIT;
              end else begin
                state_next = S_REM_RD;
              end
            end
            llnpm_pkg::CMD_LIST: begin
              if (sts.head_null) begin
                res_status_next = llnpm_pkg::ST_EMPTY;
                state_next      = S_EMIT;
              end else begin
                state_next = S_LIST_RD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (!sts.stock_empty) begin
          cmd.alloc_pop = 1'b1;
          state_next    = S_ALLOC_WAIT;
        end else if (sts.fresh_avail) begin
          cmd.alloc_fresh = 1'b1;
          state_next      = S_WRITE;
        end else begin
          res_status_next = llnpm_pkg::ST_FULL;
          state_next      = S_EMIT;
        end
      end
      S_ALLOC_WAIT: begin
        cmd.load_from_stock = 1'b1;
        state_next          = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_node  = 1'b1;
        cmd.next_head   = !is_tail;
        res_status_next = llnpm_pkg::ST_OK;
        if (!is_tail || sts.head_null) begin
          cmd.set_head_node = 1'b1;
          state_next        = S_EMIT;
        end else begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_stop) begin
          cmd.link   = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_REM_RD: begin
        cmd.rem_read = 1'b1;
        state_next   = S_REM_UPD;
      end
      S_REM_UPD: begin
        cmd.rem_update  = 1'b1;
        res_status_next = llnpm_pkg::ST_OK;
        state_next      = S_EMIT;
      end
      S_LIST_RD: begin
        cmd.list_start = 1'b1;
        state_next     = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (sts.out_free) begin
          cmd.list_emit = 1'b1;
          if (sts.list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    is_tail    <= is_tail_next;
    res_status <= res_status_next;
  end

endmodule
`default_nettype wire

// ===== tb/linked_list_node_pool_manager_unit_tb.sv =====
`timescale 1ns / 1ps

module linked_list_node_pool_manager_unit_tb;

  // Pool size of the block as built, and the index that marks the end of a chain.
  localparam int NODES = llnpm_pkg::POOL_NODES_DEF;
  localparam logic [6:0] NULL_IDX = 7'(NODES);

  // Command codes the block does not define. It must swallow them without a result.
  localparam logic [llnpm_pkg::CMD_W-1:0] CMD_RSVD_A = 3'd5;
  localparam logic [llnpm_pkg::CMD_W-1:0] CMD_RSVD_B = 3'd6;
  localparam logic [llnpm_pkg::CMD_W-1:0] CMD_RSVD_C = 3'd7;

  localparam int RANDOM_ITEMS = 400;
  localparam int BURST_LEN    = 48;
  localparam int HOLD_AT      = 140;
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 260;
  localparam int DIRECTED_ROWS = 26;

  // How a directed row is checked. A typed row carries its own status, a model
  // row goes through the shadow list, and a none row must produce nothing.
  typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} row_check_e;

  typedef struct packed {
    logic [llnpm_pkg::CMD_W-1:0]    cmd;
    logic [llnpm_pkg::DATA_W-1:0]   val;
    row_check_e                     kind;
    logic [llnpm_pkg::STATUS_W-1:0] st;
  } directed_row_t;

  typedef struct packed {
    logic [llnpm_pkg::STATUS_W-1:0] status;
    logic [llnpm_pkg::DATA_W-1:0]   value;
    logic                           last;
  } list_result_t;

  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_ANY} op_mix_e;

  logic                                  clk;
  logic                                  rst = 1'b1;
  logic                                  in_valid = 1'b0;
  wire                                   in_ready;
  logic [llnpm_pkg::CMD_W-1:0]           command = llnpm_pkg::CMD_CLEAR;
  logic signed [llnpm_pkg::DATA_W-1:0]   value_in = '0;
  wire                                   out_valid;
  wire                                   out_ready;
  wire  [llnpm_pkg::STATUS_W-1:0]        status;
  wire  signed [llnpm_pkg::DATA_W-1:0]   value_out;
  wire                                   last;

  // The receiver's own ready and the long hold-off are combined here, so
  // that the hold can be timed by a process of its own.
  logic rx_ready = 1'b0;
  logic rx_hold  = 1'b0;
  assign out_ready = rx_ready & ~rx_hold;

  linked_list_node_pool_manager_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .value_out (value_out),
    .last      (last)
  );

  // Shadow copy of the list: node contents, links, head, recycled stack and
  // the never-used counter. Only entries that the list has written are read.
  logic [llnpm_pkg::DATA_W-1:0] shadow_value [NODES];
  logic [6:0]                   shadow_next  [NODES];
  logic [5:0]                   shadow_stock [NODES];
  logic [6:0]                   shadow_head = NULL_IDX;
  int                           stock_used  = 0;
  int                           fresh_used  = 0;

  list_result_t  pending_results [$];
  directed_row_t directed_rows [DIRECTED_ROWS];

  int  mismatch_count = 0;
  int  items_sent     = 0;
  int  random_count   = 0;
  bit  idle_sender    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Takes a node from the top of the recycled stack, else from the never-used
  // counter. Returns the null index when the pool is exhausted.
  function automatic logic [6:0] claim_node();
    if (stock_used > 0) begin
      stock_used--;
      return {1'b0, shadow_stock[stock_used]};
    end
    if (fresh_used < NODES) begin
      fresh_used++;
      return 7'(fresh_used - 1);
    end
    return NULL_IDX;
  endfunction

  // Applies one accepted command to the shadow list. When record is set, the
  // results it causes are queued as expectations.
  function automatic void apply_list_command(input logic [llnpm_pkg::CMD_W-1:0] cmd,
                                             input logic [llnpm_pkg::DATA_W-1:0] val,
                                             input bit record);
    logic [6:0] node;
    logic [6:0] cur;
    int         steps;
    case (cmd)
      llnpm_pkg::CMD_CLEAR: begin
        shadow_head = NULL_IDX;
        stock_used  = 0;
        fresh_used  = 0;
        if (record) pending_results.push_back('{llnpm_pkg::ST_OK, '0, 1'b1});
      end
      llnpm_pkg::CMD_INS_HEAD, llnpm_pkg::CMD_INS_TAIL: begin
        node = claim_node();
        if (node == NULL_IDX) begin
          if (record) pending_results.push_back('{llnpm_pkg::ST_FULL, '0, 1'b1});
        end else begin
          shadow_value[node[5:0]] = val;
          if (cmd == llnpm_pkg::CMD_INS_HEAD) begin
            shadow_next[node[5:0]] = shadow_head;
            shadow_head = node;
          end else begin
            shadow_next[node[5:0]] = NULL_IDX;
            if (shadow_head == NULL_IDX) begin
              shadow_head = node;
            end else begin
              // Walk to the last node and hang the new one behind it.
              cur = shadow_head;
              for (steps = 1; steps < NODES; steps++) begin
                if (shadow_next[cur[5:0]] == NULL_IDX) break;
                cur = shadow_next[cur[5:0]];
              end
              shadow_next[cur[5:0]] = node;
            end
          end
          if (record) pending_results.push_back('{llnpm_pkg::ST_OK, '0, 1'b1});
        end
      end
      llnpm_pkg::CMD_REMOVE: begin
        if (shadow_head == NULL_IDX) begin
          if (record) pending_results.push_back('{llnpm_pkg::ST_EMPTY, '0, 1'b1});
        end else begin
          cur = shadow_head;
          shadow_head = shadow_next[cur[5:0]];
          if (stock_used < NODES) begin
            shadow_stock[stock_used] = cur[5:0];
            stock_used++;
          end
          if (record) pending_results.push_back('{llnpm_pkg::ST_OK, '0, 1'b1});
        end
      end
      llnpm_pkg::CMD_LIST: begin
        if (shadow_head == NULL_IDX) begin
          if (record) pending_results.push_back('{llnpm_pkg::ST_EMPTY, '0, 1'b1});
        end else begin
          cur = shadow_head;
          steps = 0;
          while (cur != NULL_IDX && steps < NODES) begin
            if (record) begin
              pending_results.push_back('{llnpm_pkg::ST_OK, shadow_value[cur[5:0]],
                  shadow_next[cur[5:0]] == NULL_IDX || steps == NODES - 1});
            end
            steps++;
            cur = shadow_next[cur[5:0]];
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one command, waits for its transfer and then updates the shadow
  // list. Valid stays high between back-to-back items, so it is only lowered
  // when a gap is drawn.
  task automatic send_item(input logic [llnpm_pkg::CMD_W-1:0] cmd,
                           input logic [llnpm_pkg::DATA_W-1:0] val,
                           input row_check_e kind,
                           input logic [llnpm_pkg::STATUS_W-1:0] st);
    int gap;
    gap = idle_sender ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value_in <= val;
    do @(posedge clk); while (!in_ready);
    apply_list_command(cmd, val, kind == CHK_MODEL);
    if (kind == CHK_TYPED) pending_results.push_back('{st, '0, 1'b1});
    items_sent++;
  endtask

  // Draws a command code according to the mix of the current burst. Fill
  // bursts push the pool towards exhaustion, drain bursts empty the list.
  function automatic logic [llnpm_pkg::CMD_W-1:0] pick_command(input op_mix_e mix);
    int roll;
    int head_lim, tail_lim, rem_lim, list_lim, rsvd_lim;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        head_lim = 42; tail_lim = 84; rem_lim = 90; list_lim = 97; rsvd_lim = 100;
      end
      MIX_DRAIN: begin
        head_lim = 15; tail_lim = 30; rem_lim = 82; list_lim = 94; rsvd_lim = 97;
      end
      default: begin
        head_lim = 25; tail_lim = 50; rem_lim = 75; list_lim = 92; rsvd_lim = 96;
      end
    endcase
    if (roll < head_lim) return llnpm_pkg::CMD_INS_HEAD;
    if (roll < tail_lim) return llnpm_pkg::CMD_INS_TAIL;
    if (roll < rem_lim)  return llnpm_pkg::CMD_REMOVE;
    if (roll < list_lim) return llnpm_pkg::CMD_LIST;
    if (roll < rsvd_lim) begin
      case ($urandom_range(0, 2))
        0:       return CMD_RSVD_A;
        1:       return CMD_RSVD_B;
        default: return CMD_RSVD_C;
      endcase
    end
    return llnpm_pkg::CMD_CLEAR;
  endfunction

  // Mostly random data, with the corners of the signed range now and then.
  function automatic logic [llnpm_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Receiver. It draws a stall before every result, with stretches of no
  // stalls, and compares each transfer against the oldest expectation.
  initial begin : result_receiver
    int           gap;
    int           taken;
    bit           no_stall;
    list_result_t want;
    taken = 0;
    no_stall = 1'b0;
    forever begin
      if (taken % 40 == 0) no_stall = ($urandom_range(0, 3) == 0);
      gap = no_stall ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rx_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rx_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status=%0d value=%h last=%0b",
                   status, value_out, last);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || value_out !== want.value || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: expected status=%0d value=%h last=%0b, ",
                      "got status=%0d value=%h last=%0b"},
                     want.status, want.value, want.last, status, value_out, last);
        end
      end
    end
  end

  // Long hold-off on the result side. The sender keeps offering items, so the
  // block finishes its command, parks the result and then stalls its input.
  initial begin : result_hold_off
    while (items_sent < DIRECTED_ROWS + HOLD_AT) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Main sequence: reset, the directed table, then bursts of random commands.
  initial begin : stimulus
    logic [llnpm_pkg::CMD_W-1:0] cmd;
    op_mix_e                     mix;
    int                          burst;
    bit                          paused;

    directed_rows = '{
      // An empty list after reset answers remove and list with status empty.
      '{llnpm_pkg::CMD_REMOVE,   32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_EMPTY},
      '{llnpm_pkg::CMD_LIST,     32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_EMPTY},
      '{CMD_RSVD_A,              32'hdead_beef, CHK_NONE,  llnpm_pkg::ST_OK},
      // Extremes of the value range at both ends of the list.
      '{llnpm_pkg::CMD_INS_HEAD, 32'h7fff_ffff, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_INS_HEAD, 32'h8000_0000, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_INS_TAIL, 32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_INS_TAIL, 32'hffff_ffff, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_LIST,     32'h0000_0000, CHK_MODEL, llnpm_pkg::ST_OK},
      '{CMD_RSVD_B,              32'h0000_0001, CHK_NONE,  llnpm_pkg::ST_OK},
      '{CMD_RSVD_C,              32'hffff_ffff, CHK_NONE,  llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_REMOVE,   32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_LIST,     32'h0000_0000, CHK_MODEL, llnpm_pkg::ST_OK},
      // Clear drops the list and the pool.
      '{llnpm_pkg::CMD_CLEAR,    32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_LIST,     32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_EMPTY},
      '{llnpm_pkg::CMD_REMOVE,   32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_EMPTY},
      // A tail insert on an empty list becomes the head.
      '{llnpm_pkg::CMD_INS_TAIL, 32'h0000_0005, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_INS_HEAD, 32'h5555_5555, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_INS_TAIL, 32'haaaa_aaaa, CHK_MODEL, llnpm_pkg::ST_OK},
      // Drain past empty so the recycled stack holds three nodes.
      '{llnpm_pkg::CMD_REMOVE,   32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_REMOVE,   32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_REMOVE,   32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_REMOVE,   32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_EMPTY},
      // These inserts are served from the recycled stack.
      '{llnpm_pkg::CMD_INS_HEAD, 32'h0000_1234, CHK_MODEL, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_INS_TAIL, 32'h1234_5678, CHK_MODEL, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_LIST,     32'h0000_0000, CHK_MODEL, llnpm_pkg::ST_OK},
      '{llnpm_pkg::CMD_CLEAR,    32'h0000_0000, CHK_TYPED, llnpm_pkg::ST_OK}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_item(directed_rows[i].cmd, directed_rows[i].val,
                directed_rows[i].kind, directed_rows[i].st);

    // The first two bursts fill the pool so that exhaustion is reached early;
    // after that the mix is drawn per burst.
    burst  = 0;
    mix    = MIX_FILL;
    paused = 1'b0;
    while (random_count < RANDOM_ITEMS) begin
      if (random_count % BURST_LEN == 0) begin
        if (burst >= 2) begin
          case ($urandom_range(0, 2))
            0:       mix = MIX_FILL;
            1:       mix = MIX_DRAIN;
            default: mix = MIX_ANY;
          endcase
        end
        idle_sender = ($urandom_range(0, 3) == 0);
        burst++;
      end
      // Once, let the block drain completely before going on.
      if (!paused && random_count == PAUSE_AT) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      cmd = pick_command(mix);
      send_item(cmd, pick_value(), CHK_MODEL, llnpm_pkg::ST_OK);
      if (cmd <= llnpm_pkg::CMD_LIST) random_count++;
      else if (random_count % BURST_LEN == 0) random_count = random_count;
    end
    in_valid <= 1'b0;

    // Wait for every expected result, then a little longer for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NODES + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Safety net for a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
